// ===== design/tbpd_pkg.sv =====
// Shared types and constants for the two-of-five bar pair decoder.
// No dependencies; imported by the front, queue, back and top modules.
`timescale 1ns / 1ps

package tbpd_pkg;

	// configuration register indexes and widths
	localparam logic [1:0] REG_END_THRESHOLD = 2'd0;
	localparam logic [1:0] REG_LEAD_IN_PAIRS = 2'd1;
	localparam int THRESH_W = 24;
	localparam int LEAD_W = 4;
	localparam int CFG_DATA_W = 24;
	localparam int CFG_INDEX_W = 2;
	localparam logic [THRESH_W-1:0] THRESH_RESET = 24'h001000;
	localparam logic [LEAD_W-1:0] LEAD_RESET = 4'd2;

	// characters
	localparam logic [7:0] CH_START = 8'h53;
	localparam logic [7:0] CH_END = 8'h45;
	localparam logic [7:0] CH_NEWLINE = 8'h0A;
	localparam logic [7:0] CH_ZERO = 8'h30;
	localparam logic [3:0] INVALID_DIGIT = 4'd10;

	// bit positions of the per-word character mask, in send order
	localparam int M_START = 0;
	localparam int M_DIGIT = 1;
	localparam int M_END = 2;
	localparam int M_NL = 3;
	localparam int MASK_W = 4;

	// group position of the fifth bit
	localparam logic [2:0] GROUP_LAST = 3'd4;

	// queue between front and back
	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W = 2;

	// one classified bar pair, waiting for the back end
	typedef struct packed {
		logic [MASK_W-1:0] mask;
		logic [7:0] digit_char;
		logic [31:0] disp;
		logic [15:0] count;
		logic ended;
	} entry_t;

	// two-of-five code to digit; anything else is invalid
	function automatic logic [3:0] digit_of_code(input logic [4:0] code);
		logic [3:0] d;
		case (code)
			5'd3: d = 4'd7;
			5'd5: d = 4'd4;
			5'd6: d = 4'd0;
			5'd9: d = 4'd2;
			5'd10: d = 4'd9;
			5'd12: d = 4'd6;
			5'd17: d = 4'd1;
			5'd18: d = 4'd8;
			5'd20: d = 4'd5;
			5'd24: d = 4'd3;
			default: d = INVALID_DIGIT;
		endcase
		return d;
	endfunction

endpackage

// ===== design/tbpd_front.sv =====
// Front end: configuration registers, bar classification and scan state.
// Depends on tbpd_pkg; pushes one entry_t per accepted pair.
`timescale 1ns / 1ps

module tbpd_front #(
	parameter int TIME_WIDTH = 24,
	parameter int COUNT_WIDTH = 16
) (
	input  logic clk,
	input  logic arst_n,
	input  logic cfg_valid,
	output logic cfg_ready,
	input  logic [tbpd_pkg::CFG_INDEX_W-1:0] cfg_index,
	input  logic [tbpd_pkg::CFG_DATA_W-1:0] cfg_data,
	input  logic in_valid,
	output logic in_ready,
	input  logic [TIME_WIDTH-1:0] white_time,
	input  logic [TIME_WIDTH-1:0] black_time,
	input  logic q_full,
	output logic push,
	output tbpd_pkg::entry_t push_entry
);
	import tbpd_pkg::*;

	localparam int WW = TIME_WIDTH + 2;
	localparam int CMPW = (TIME_WIDTH > THRESH_W) ? TIME_WIDTH : THRESH_W;

	logic [THRESH_W-1:0] end_threshold_q;
	logic [LEAD_W-1:0] lead_in_q;
	logic [COUNT_WIDTH-1:0] pair_count_q;
	logic [4:0] bit_group_q;
	logic [2:0] group_pos_q;
	logic scan_open_q;

	logic [WW-1:0] w_ext, b_ext, half_w, three_half_w;
	logic bit_one, ended, grouping, digit_done;
	logic [COUNT_WIDTH-1:0] cnt_base, cnt_next;
	logic [4:0] grp_base, grp_next;
	logic [2:0] pos_base, pos_next;
	logic [3:0] digit;

	assign cfg_ready = 1'b1;
	assign in_ready = !q_full;
	assign push = in_valid && in_ready;

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			end_threshold_q <= THRESH_RESET;
			lead_in_q <= LEAD_RESET;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_END_THRESHOLD: end_threshold_q <= cfg_data[THRESH_W-1:0];
				REG_LEAD_IN_PAIRS: lead_in_q <= cfg_data[LEAD_W-1:0];
				default: ;
			endcase
		end
	end

	// pair classification: bit 0 when black lies strictly inside (w/2, 3w/2)
	always_comb begin
		w_ext = WW'(white_time);
		b_ext = WW'(black_time);
		half_w = w_ext >> 1;
		three_half_w = ((w_ext << 1) + w_ext) >> 1;
		bit_one = !((b_ext > half_w) && (b_ext < three_half_w));
		ended = CMPW'(white_time) >= CMPW'(end_threshold_q);
	end

	// scan state update; an opening pair starts from cleared state
	always_comb begin
		cnt_base = scan_open_q ? pair_count_q : '0;
		grp_base = scan_open_q ? bit_group_q : '0;
		pos_base = scan_open_q ? group_pos_q : '0;
		grouping = cnt_base >= COUNT_WIDTH'(lead_in_q);
		grp_next = grouping ? {grp_base[3:0], bit_one} : grp_base;
		digit_done = grouping && (pos_base >= GROUP_LAST);
		if (!grouping)
			pos_next = pos_base;
		else if (digit_done)
			pos_next = '0;
		else
			pos_next = pos_base + 3'd1;
		cnt_next = (cnt_base == '1) ? cnt_base : cnt_base + 1'b1;
		digit = digit_of_code(grp_next);
	end

	// entry for the back end
	always_comb begin
		push_entry.mask = '0;
		push_entry.mask[M_START] = !scan_open_q;
		push_entry.mask[M_DIGIT] = digit_done;
		push_entry.mask[M_END] = ended;
		push_entry.mask[M_NL] = ended;
		push_entry.digit_char = CH_ZERO + {4'd0, digit};
		push_entry.disp = 32'({white_time, 16'd0}) | 32'(black_time);
		push_entry.count = 16'(cnt_next);
		push_entry.ended = ended;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pair_count_q <= '0;
			bit_group_q <= '0;
			group_pos_q <= '0;
			scan_open_q <= 1'b0;
		end else if (push) begin
			pair_count_q <= cnt_next;
			bit_group_q <= grp_next;
			group_pos_q <= pos_next;
			scan_open_q <= !ended;
		end
	end

endmodule

// ===== design/tbpd_queue.sv =====
// Small FIFO of classified pairs between front and back.
// Depends on tbpd_pkg for entry_t and the depth constants.
`timescale 1ns / 1ps

module tbpd_queue (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  tbpd_pkg::entry_t push_entry,
	output logic full,
	input  logic pop,
	output logic head_valid,
	output tbpd_pkg::entry_t head
);
	import tbpd_pkg::*;

	entry_t slots_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [QPTR_W:0] fill_q;

	assign full = fill_q == (QPTR_W+1)'(QUEUE_DEPTH);
	assign head_valid = fill_q != '0;
	assign head = slots_q[rd_ptr_q];

	// storage; payload needs no reset
	always_ff @(posedge clk) begin
		if (push)
			slots_q[wr_ptr_q] <= push_entry;
	end

	// pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q <= '0;
		end else begin
			if (push)
				wr_ptr_q <= wr_ptr_q + 1'b1;
			if (pop)
				rd_ptr_q <= rd_ptr_q + 1'b1;
			if (push && !pop)
				fill_q <= fill_q + 1'b1;
			else if (pop && !push)
				fill_q <= fill_q - 1'b1;
		end
	end

endmodule

// ===== design/tbpd_back.sv =====
// Back end: expands a queued pair into result words, one per ready cycle.
// Depends on tbpd_pkg; reads the queue head and drives the output register.
`timescale 1ns / 1ps

module tbpd_back (
	input  logic clk,
	input  logic arst_n,
	input  logic head_valid,
	input  tbpd_pkg::entry_t head,
	output logic pop,
	output logic out_valid,
	input  logic out_ready,
	output logic char_valid,
	output logic [7:0] char_code,
	output logic [31:0] display_word,
	output logic [15:0] bar_count,
	output logic end_of_scan,
	output logic last
);
	import tbpd_pkg::*;

	logic [MASK_W-1:0] done_q, pending, sel;
	logic out_valid_q;
	logic char_valid_q, end_of_scan_q, last_q;
	logic [7:0] char_code_q, char_sel;
	logic [31:0] disp_q;
	logic [15:0] count_q;
	logic load, is_last;

	// next character of the head word: lowest pending mask bit
	always_comb begin
		pending = head.mask & ~done_q;
		sel = pending & (~pending + 1'b1);
		is_last = (pending & ~sel) == '0;
		case (sel)
			MASK_W'(1) << M_START: char_sel = CH_START;
			MASK_W'(1) << M_DIGIT: char_sel = head.digit_char;
			MASK_W'(1) << M_END: char_sel = CH_END;
			MASK_W'(1) << M_NL: char_sel = CH_NEWLINE;
			default: char_sel = 8'd0;
		endcase
	end

	assign load = head_valid && (!out_valid_q || out_ready);
	assign pop = load && is_last;

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			done_q <= '0;
		end else begin
			if (load)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
			if (pop)
				done_q <= '0;
			else if (load)
				done_q <= done_q | sel;
		end
	end

	// output payload
	always_ff @(posedge clk) begin
		if (load) begin
			char_valid_q <= head.mask != '0;
			char_code_q <= char_sel;
			disp_q <= head.disp;
			count_q <= head.count;
			end_of_scan_q <= head.ended;
			last_q <= is_last;
		end
	end

	assign out_valid = out_valid_q;
	assign char_valid = char_valid_q;
	assign char_code = char_code_q;
	assign display_word = disp_q;
	assign bar_count = count_q;
	assign end_of_scan = end_of_scan_q;
	assign last = last_q;

	// a word without a character is always the only one of its pair
	a_nochar_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !char_valid |-> last)
		else $error("word without character not marked last");

	// newline closes the scan and is the final word of its pair
	a_nl_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && char_valid && char_code == CH_NEWLINE |-> last && end_of_scan)
		else $error("newline not last or not end of scan");

	// the rest of a pair follows without a gap
	a_no_gap: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready && !last |=> out_valid)
		else $error("gap inside the words of one pair");

endmodule

// ===== design/two_of_five_bar_pair_decoder.sv =====
// Top level of the two-of-five bar pair decoder.
// Instantiates tbpd_front, tbpd_queue and tbpd_back; uses tbpd_pkg.
//
// Each accepted word is one white/black bar-time pair; it yields one to four
// result words ('S', a digit or ':', 'E' and newline, or a single word with
// char_valid low). The front end classifies a pair and updates the scan state
// in the cycle it is accepted, so pairs may arrive every cycle while the
// four-entry queue has room. The back end sends one result word per cycle
// from its output register while out_ready is high; the sustained pair rate
// is set by the number of result words per pair. Configuration: index 0 end
// threshold, index 1 lead-in pair count; cfg_ready is always high. No
// clearing pass after reset.
`timescale 1ns / 1ps

module two_of_five_bar_pair_decoder #(
	parameter int TIME_WIDTH = 24,
	parameter int COUNT_WIDTH = 16
) (
	input  logic clk,
	input  logic arst_n,
	input  logic cfg_valid,
	output logic cfg_ready,
	input  logic [tbpd_pkg::CFG_INDEX_W-1:0] cfg_index,
	input  logic [tbpd_pkg::CFG_DATA_W-1:0] cfg_data,
	input  logic in_valid,
	output logic in_ready,
	input  logic [TIME_WIDTH-1:0] white_time,
	input  logic [TIME_WIDTH-1:0] black_time,
	output logic out_valid,
	input  logic out_ready,
	output logic char_valid,
	output logic [7:0] char_code,
	output logic [31:0] display_word,
	output logic [15:0] bar_count,
	output logic end_of_scan,
	output logic last
);
	import tbpd_pkg::*;

	entry_t push_entry, head;
	logic push, pop, q_full, head_valid;

	// classify and update scan state
	tbpd_front #(
		.TIME_WIDTH(TIME_WIDTH),
		.COUNT_WIDTH(COUNT_WIDTH)
	) u_front (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.white_time(white_time),
		.black_time(black_time),
		.q_full(q_full),
		.push(push),
		.push_entry(push_entry)
	);

	// decoupling queue
	tbpd_queue u_queue (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.push_entry(push_entry),
		.full(q_full),
		.pop(pop),
		.head_valid(head_valid),
		.head(head)
	);

	// result sequencing
	tbpd_back u_back (
		.clk(clk),
		.arst_n(arst_n),
		.head_valid(head_valid),
		.head(head),
		.pop(pop),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.char_valid(char_valid),
		.char_code(char_code),
		.display_word(display_word),
		.bar_count(bar_count),
		.end_of_scan(end_of_scan),
		.last(last)
	);

endmodule

// ===== test/tb_top.sv =====
// Testbench for two_of_five_bar_pair_decoder: random and directed bar pairs, with scoreboard.
// Depends on tbpd_pkg and the decoder RTL; it predicts every character word and checks it.
`timescale 1ns / 1ps

module tb_top;
	import tbpd_pkg::*;

	localparam int TIME_W = 24;
	localparam int unsigned TIME_MAX = 24'hFFFFFF;
	localparam logic [CFG_INDEX_W-1:0] REG_SPARE = 2'd3;
	localparam int RANDOM_PAIRS = 15;
	localparam int MAX_PRINTS = 100;

	typedef struct packed {
		logic [TIME_W-1:0] white;
		logic [TIME_W-1:0] black;
	} bar_pair_t;

	typedef struct packed {
		logic char_valid;
		logic [7:0] char_code;
		logic [31:0] display_word;
		logic [15:0] bar_count;
		logic end_of_scan;
		logic last;
	} char_word_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [CFG_INDEX_W-1:0] cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic [TIME_W-1:0] white_time = '0;
	logic [TIME_W-1:0] black_time = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic char_valid;
	logic [7:0] char_code;
	logic [31:0] display_word;
	logic [15:0] bar_count;
	logic end_of_scan;
	logic last;

	// stimulus side
	bar_pair_t pending_pairs[$];
	bar_pair_t drv_pair;
	int unsigned gen_thr = 32'(THRESH_RESET);
	int unsigned gen_lead = 32'(LEAD_RESET);
	int unsigned pushed_pairs = 0;
	int next_digit = 0;
	bit idle_on = 1'b1;
	int gap_left = 0;
	int stall_left = 0;

	// predictor state and scoreboard
	char_word_t expected_chars[$];
	logic [THRESH_W-1:0] thr_shadow = THRESH_RESET;
	logic [LEAD_W-1:0] lead_shadow = LEAD_RESET;
	logic scan_live = 1'b0;
	logic [15:0] bars_seen = '0;
	logic [4:0] group_bits = '0;
	logic [2:0] group_pos = '0;
	int err_count = 0;

	two_of_five_bar_pair_decoder DUT (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.white_time(white_time),
		.black_time(black_time),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.char_valid(char_valid),
		.char_code(char_code),
		.display_word(display_word),
		.bar_count(bar_count),
		.end_of_scan(end_of_scan),
		.last(last)
	);

	always #1 clk = ~clk;

	// two-of-five by weights 1,2,4,7,0; the pair 4+7 stands for zero
	function automatic logic [3:0] digit_of(input logic [4:0] code);
		int unsigned weight_sum;
		weight_sum = (code[4] ? 1 : 0) + (code[3] ? 2 : 0) + (code[2] ? 4 : 0)
			+ (code[1] ? 7 : 0);
		if ($countones(code) != 2)
			return INVALID_DIGIT;
		return (weight_sum == 11) ? 4'd0 : weight_sum[3:0];
	endfunction

	task automatic report_mismatch(input string msg);
		if (err_count < MAX_PRINTS)
			$display("[%0t] mismatch: %s", $time, msg);
		err_count++;
	endtask

	task automatic check_field(input string name, input logic [31:0] got,
			input logic [31:0] want);
		if (got !== want)
			report_mismatch($sformatf("%s got %0h want %0h", name, got, want));
	endtask

	// work out the character words one bar pair causes and queue them
	task automatic decode_pair(input logic [TIME_W-1:0] w, input logic [TIME_W-1:0] b);
		logic [7:0] chars [4];
		int n;
		int k;
		int unsigned wi, bi;
		logic one, ended;
		logic [31:0] disp;
		char_word_t cw;
		n = 0;
		if (!scan_live) begin
			scan_live = 1'b1;
			bars_seen = '0;
			group_bits = '0;
			group_pos = '0;
			chars[n] = CH_START;
			n++;
		end
		wi = 32'(w);
		bi = 32'(b);
		one = !(bi > wi / 2 && bi < (wi * 3) / 2);
		// lead-in compared live against the count before this pair
		if (bars_seen >= lead_shadow) begin
			group_bits = {group_bits[3:0], one};
			if (group_pos == GROUP_LAST) begin
				chars[n] = CH_ZERO + digit_of(group_bits);
				n++;
				group_pos = '0;
			end else begin
				group_pos++;
			end
		end
		if (bars_seen != 16'hFFFF)
			bars_seen++;
		disp = {w[15:0], 16'h0000} | {8'h00, b};
		ended = (w >= thr_shadow);
		if (ended) begin
			chars[n] = CH_END;
			n++;
			chars[n] = CH_NEWLINE;
			n++;
			scan_live = 1'b0;
		end
		cw.display_word = disp;
		cw.bar_count = bars_seen;
		cw.end_of_scan = ended;
		if (n == 0) begin
			cw.char_valid = 1'b0;
			cw.char_code = 8'h00;
			cw.last = 1'b1;
			expected_chars.push_back(cw);
		end
		for (k = 0; k < n; k++) begin
			cw.char_valid = 1'b1;
			cw.char_code = chars[k];
			cw.last = (k == n - 1);
			expected_chars.push_back(cw);
		end
	endtask

	// register shadow, prediction on accepted pairs, check on accepted words
	always @(posedge clk) begin
		char_word_t want;
		if (arst_n) begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					REG_END_THRESHOLD: thr_shadow = cfg_data[THRESH_W-1:0];
					REG_LEAD_IN_PAIRS: lead_shadow = cfg_data[LEAD_W-1:0];
					default: ;
				endcase
			end
			if (in_valid && in_ready)
				decode_pair(white_time, black_time);
			if (out_valid && out_ready) begin
				if (expected_chars.size() == 0) begin
					report_mismatch($sformatf("unexpected word, char_code %0h", char_code));
				end else begin
					want = expected_chars.pop_front();
					check_field("char_valid", 32'(char_valid), 32'(want.char_valid));
					check_field("char_code", 32'(char_code), 32'(want.char_code));
					check_field("display_word", display_word, want.display_word);
					check_field("bar_count", 32'(bar_count), 32'(want.bar_count));
					check_field("end_of_scan", 32'(end_of_scan), 32'(want.end_of_scan));
					check_field("last", 32'(last), 32'(want.last));
				end
			end
		end
	end

	// pair driver: pops pending pairs, with random gaps after some words
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			white_time <= '0;
			black_time <= '0;
			gap_left <= 0;
		end else if (!in_valid || in_ready) begin
			if (gap_left != 0) begin
				in_valid <= 1'b0;
				gap_left <= gap_left - 1;
			end else if (pending_pairs.size() != 0) begin
				drv_pair = pending_pairs.pop_front();
				in_valid <= 1'b1;
				white_time <= drv_pair.white;
				black_time <= drv_pair.black;
				if (idle_on && $urandom_range(0, 3) == 0)
					gap_left <= $urandom_range(1, 7);
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// receiver back-pressure in bursts
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
			stall_left <= 0;
		end else if (stall_left != 0) begin
			out_ready <= 1'b0;
			stall_left <= stall_left - 1;
		end else begin
			out_ready <= 1'b1;
			if (idle_on && $urandom_range(0, 4) == 0)
				stall_left <= $urandom_range(1, 7);
		end
	end

	task automatic add_bar(input logic [TIME_W-1:0] w, input logic [TIME_W-1:0] b);
		bar_pair_t p;
		p.white = w;
		p.black = b;
		pending_pairs.push_back(p);
		pushed_pairs++;
	endtask

	// pair carrying a chosen bit where the threshold allows; ending pairs reach the threshold
	task automatic add_coded(input logic one, input logic ending);
		int unsigned w, lo, hi;
		if (ending || gen_thr == 0) begin
			w = $urandom_range(gen_thr, TIME_MAX);
		end else begin
			hi = gen_thr - 1;
			if (hi > 63 && $urandom_range(0, 3) == 0)
				hi = 63;
			w = $urandom_range(0, hi);
		end
		lo = w / 2;
		hi = (3 * w) / 2;
		if (!one && hi - lo >= 2)
			add_bar(TIME_W'(w), TIME_W'($urandom_range(lo + 1, hi - 1)));
		else if (hi > TIME_MAX || $urandom_range(0, 1) == 0)
			add_bar(TIME_W'(w), TIME_W'($urandom_range(0, lo)));
		else
			add_bar(TIME_W'(w), TIME_W'($urandom_range(hi, TIME_MAX)));
	endtask

	// lead-in, digit groups (mostly valid, digits in rotation), optional stray bits, end
	task automatic push_scan(input int n_digits, input logic ragged);
		int k, b, c;
		logic [4:0] code;
		for (k = 0; k < gen_lead; k++)
			add_coded(1'($urandom_range(0, 1)), 1'b0);
		for (k = 0; k < n_digits; k++) begin
			if ($urandom_range(0, 4) == 0) begin
				code = 5'($urandom_range(0, 31));
			end else begin
				for (c = 0; c < 32; c++)
					if (digit_of(5'(c)) == next_digit)
						code = 5'(c);
				next_digit = (next_digit + 1) % 10;
			end
			for (b = 4; b >= 0; b--)
				add_coded(code[b], 1'b0);
		end
		if (ragged)
			for (k = $urandom_range(1, 4); k > 0; k--)
				add_coded(1'($urandom_range(0, 1)), 1'b0);
		add_coded(1'($urandom_range(0, 1)), 1'b1);
	endtask

	task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input int unsigned val);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= CFG_DATA_W'(val);
		do @(posedge clk);
		while (!cfg_ready);
		cfg_valid <= 1'b0;
		if (idx == REG_END_THRESHOLD)
			gen_thr = val & TIME_MAX;
		else if (idx == REG_LEAD_IN_PAIRS)
			gen_lead = val & 4'hF;
		@(negedge clk);
	endtask

	task automatic wait_drained();
		do @(negedge clk);
		while (pending_pairs.size() != 0 || in_valid || expected_chars.size() != 0);
	endtask

	initial begin
		int k;
		int unsigned start_count, thr;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// reset settings: lead-in of two, threshold 4096
		add_bar(24'd0, 24'd0);
		add_bar(24'd4095, 24'hFFFFFF);
		// digit 0: both bounds of the bit-zero window
		add_bar(24'd10, 24'd6);
		add_bar(24'd10, 24'd14);
		add_bar(24'd10, 24'd5);
		add_bar(24'd10, 24'd15);
		add_bar(24'd4095, 24'd4095);
		// all ones: invalid code
		add_bar(24'd0, 24'd0);
		add_bar(24'd1, 24'd0);
		add_bar(24'd1, 24'd1);
		add_bar(24'd2, 24'd1);
		add_bar(24'd2, 24'd3);
		// digit 3 near the upper bound
		add_bar(24'd4095, 24'd0);
		add_bar(24'd4095, 24'd6142);
		add_bar(24'd4095, 24'd6141);
		add_bar(24'd4095, 24'd2048);
		add_bar(24'd3, 24'd2);
		// close on the widest pair, then a pair that opens and closes at the threshold
		add_bar(24'hFFFFFF, 24'hFFFFFF);
		add_bar(24'd4096, 24'd0);
		add_bar(24'd4095, 24'd0);
		add_bar(24'h800000, 24'h7FFFFF);
		wait_drained();

		// spare index, nothing behind it
		write_reg(REG_SPARE, $urandom_range(0, TIME_MAX));
		// zero threshold: every pair is a scan of its own
		write_reg(REG_END_THRESHOLD, 0);
		write_reg(REG_LEAD_IN_PAIRS, 0);
		for (k = 0; k < 6; k++)
			add_bar(TIME_W'($urandom_range(0, TIME_MAX)),
				TIME_W'($urandom_range(0, TIME_MAX)));
		add_bar(24'd0, 24'd0);
		wait_drained();

		// widest threshold, longest lead-in
		write_reg(REG_END_THRESHOLD, TIME_MAX);
		write_reg(REG_LEAD_IN_PAIRS, 15);
		push_scan(1, 1'b1);
		wait_drained();

		// lead-in raised while a scan is open, then lowered again
		write_reg(REG_LEAD_IN_PAIRS, 0);
		for (k = 0; k < 3; k++)
			add_coded(1'($urandom_range(0, 1)), 1'b0);
		wait_drained();
		write_reg(REG_LEAD_IN_PAIRS, ($urandom_range(0, 20'hFFFFF) << 4) | 15);
		for (k = 0; k < 8; k++)
			add_coded(1'($urandom_range(0, 1)), 1'b0);
		wait_drained();
		write_reg(REG_LEAD_IN_PAIRS, 1);
		for (k = 0; k < 10; k++)
			add_coded(1'($urandom_range(0, 1)), 1'b0);
		add_coded(1'b0, 1'b1);
		wait_drained();

		// random settings, mostly well-formed scans with some noise
		start_count = pushed_pairs;
		while (pushed_pairs - start_count < RANDOM_PAIRS) begin
			case ($urandom_range(0, 5))
				0: thr = 0;
				1: thr = TIME_MAX;
				2: thr = $urandom_range(1, 8);
				3: thr = THRESH_RESET;
				default: thr = $urandom_range(16, 1 << $urandom_range(5, 24)) & TIME_MAX;
			endcase
			write_reg(REG_END_THRESHOLD, thr);
			write_reg(REG_LEAD_IN_PAIRS, ($urandom_range(0, 3) == 0)
				? $urandom_range(0, TIME_MAX) : $urandom_range(0, 15));
			repeat ($urandom_range(1, 3)) begin
				if ($urandom_range(0, 3) == 0)
					repeat ($urandom_range(1, 3))
						add_bar(TIME_W'($urandom_range(0, TIME_MAX)),
							TIME_W'($urandom_range(0, TIME_MAX)));
				else
					push_scan($urandom_range(0, 3), 1'($urandom_range(0, 1)));
			end
			wait_drained();
		end

		// one last scan at full speed, no idling on either side
		idle_on = 1'b0;
		write_reg(REG_END_THRESHOLD, TIME_MAX);
		write_reg(REG_LEAD_IN_PAIRS, 0);
		push_scan(2, 1'b1);
		wait_drained();

		repeat (20) @(posedge clk);
		if (err_count == 0)
			$display("tb_top: clean");
		else
			$display("tb_top: errors");
		$finish;
	end

	// run limit
	initial begin
		#2000000;
		$display("tb_top: errors");
		$finish;
	end

endmodule
